/* sv/pfde_pkg.sv */
`default_nettype none

package pfde_pkg;

    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 64;
    localparam int PAGE_ROWS         = 8;

    localparam logic [7:0] BYTE_FULL  = 8'hFF;
    localparam logic [7:0] BYTE_EMPTY = 8'h00;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_PLOT  = 2'd1,
        MODE_FILL  = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    localparam logic [1:0] INK_WHITE = 2'd0;
    localparam logic [1:0] INK_BLACK = 2'd1;
    localparam logic [1:0] INK_NONE  = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_READ,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

/* sv/page_framebuffer_draw_engine_unit.sv */
`default_nettype none

// Monochrome page framebuffer: SCREEN_WIDTH columns by SCREEN_HEIGHT/8 pages,
// one byte per column per page (bit k is row page*8+k), held in one
// synchronous RAM with a single write port and a single registered read port.
// One command beat is taken at a time and each gives exactly one read_byte
// beat (zero except for a read). After reset the RAM is zeroed by a sweep over
// all SCREEN_WIDTH*SCREEN_HEIGHT/8 bytes (1024 by default) before the first beat
// is taken. A clear-all runs that sweep again and then finishes; a plot or a
// rectangle fill runs a read-modify-write walk over the pages x columns touched,
// streaming one column byte per cycle through the RAM read port; a read does one
// registered RAM read. Empty, off-screen, transparent and off-screen-read commands
// go straight to finish without touching the RAM. The next command is taken while
// the previous result still waits on out_stall.
module page_framebuffer_draw_engine_unit #(
    parameter int SCREEN_WIDTH  = pfde_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = pfde_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] mode,
    input  wire logic [6:0] x_first,
    input  wire logic [5:0] y_first,
    input  wire logic [6:0] x_last,
    input  wire logic [5:0] y_last,
    input  wire logic [1:0] ink,

    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      read_byte
);

    import pfde_pkg::*;

    localparam int PAGE_COUNT = SCREEN_HEIGHT / PAGE_ROWS;
    localparam int MAX_ROW    = PAGE_COUNT * PAGE_ROWS;
    localparam int DEPTH      = SCREEN_WIDTH * PAGE_COUNT;
    localparam int COL_W      = $clog2(SCREEN_WIDTH);
    localparam int PG_W       = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int ADDR_W     = $clog2(DEPTH);

    logic [7:0] frame_store [DEPTH];

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] clear_addr_reg, clear_addr_next;
    logic              pending_reg, pending_next;
    logic              read_ok_reg, read_ok_next;
    logic              wr_pending_reg, wr_pending_next;
    logic              out_valid_reg, out_valid_next;
    logic [PG_W-1:0]   walk_page_reg, walk_page_next;
    logic [COL_W-1:0]  walk_column_reg, walk_column_next;

    logic [COL_W-1:0]  col_first_reg, col_first_next;
    logic [COL_W-1:0]  col_last_reg, col_last_next;
    logic [PG_W-1:0]   page_first_reg, page_first_next;
    logic [PG_W-1:0]   page_last_reg, page_last_next;
    logic [2:0]        seg_first_reg, seg_first_next;
    logic [2:0]        seg_last_reg, seg_last_next;
    logic [1:0]        ink_reg, ink_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic [7:0]        wr_mask_reg, wr_mask_next;
    logic [7:0]        read_byte_reg, read_byte_next;
    logic [7:0]        rd_data_reg;

    mode_t             cmd_mode;
    logic              in_fire;
    logic              out_free;
    logic [6:0]        end_x;
    logic [5:0]        end_y;
    logic              rect_empty;
    logic              start_off;
    logic              ink_ok;
    logic              do_walk;
    logic              read_hit;
    logic              clear_last;
    logic              walk_last;
    logic [2:0]        seg_lo;
    logic [2:0]        seg_hi;
    logic [7:0]        walk_mask;
    logic [ADDR_W-1:0] walk_addr;

    logic              mem_re;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;

    assign cmd_mode  = mode_t'(mode);
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign end_x      = (cmd_mode == MODE_PLOT) ? x_first : x_last;
    assign end_y      = (cmd_mode == MODE_PLOT) ? y_first : y_last;
    assign rect_empty = (end_x < x_first) || (end_y < y_first);
    assign start_off  = (int'(x_first) >= SCREEN_WIDTH) || (int'(y_first) >= MAX_ROW);
    assign ink_ok     = (ink == INK_WHITE) || (ink == INK_BLACK);
    assign do_walk    = ((cmd_mode == MODE_PLOT) || (cmd_mode == MODE_FILL))
                        && !rect_empty && !start_off && ink_ok;
    assign read_hit   = (cmd_mode == MODE_READ) && !start_off;

    assign clear_last = (clear_addr_reg == ADDR_W'(DEPTH - 1));
    assign walk_last  = (walk_column_reg == col_last_reg) && (walk_page_reg == page_last_reg);
    assign seg_lo     = (walk_page_reg == page_first_reg) ? seg_first_reg : 3'd0;
    assign seg_hi     = (walk_page_reg == page_last_reg) ? seg_last_reg : 3'd7;
    assign walk_mask  = (BYTE_FULL << seg_lo) & (BYTE_FULL >> (3'd7 - seg_hi));
    assign walk_addr  = ADDR_W'(int'(walk_page_reg) * SCREEN_WIDTH + int'(walk_column_reg));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = pending_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (cmd_mode)
                        MODE_CLEAR: state_next = ST_CLEAR;
                        MODE_READ:  state_next = read_hit ? ST_READ : ST_FINISH;
                        default:    state_next = do_walk ? ST_WALK : ST_FINISH;
                    endcase
                end
            end
            ST_WALK:
            begin
                if (walk_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_READ:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        clear_addr_next  = clear_addr_reg;
        pending_next     = pending_reg;
        read_ok_next     = read_ok_reg;
        wr_pending_next  = 1'b0;
        out_valid_next   = out_valid_reg && out_stall;
        walk_page_next   = walk_page_reg;
        walk_column_next = walk_column_reg;
        col_first_next   = col_first_reg;
        col_last_next    = col_last_reg;
        page_first_next  = page_first_reg;
        page_last_next   = page_last_reg;
        seg_first_next   = seg_first_reg;
        seg_last_next    = seg_last_reg;
        ink_next         = ink_reg;
        wr_addr_next     = wr_addr_reg;
        wr_mask_next     = wr_mask_reg;
        read_byte_next   = read_byte_reg;
        mem_re           = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                clear_addr_next = clear_last ? '0 : clear_addr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    pending_next     = 1'b1;
                    read_ok_next     = read_hit;
                    ink_next         = ink;
                    col_first_next   = COL_W'(x_first);
                    col_last_next    = (int'(end_x) >= SCREEN_WIDTH)
                                       ? COL_W'(SCREEN_WIDTH - 1) : COL_W'(end_x);
                    page_first_next  = PG_W'(y_first >> 3);
                    seg_first_next   = y_first[2:0];
                    page_last_next   = (int'(end_y) >= MAX_ROW)
                                       ? PG_W'(PAGE_COUNT - 1) : PG_W'(end_y >> 3);
                    seg_last_next    = (int'(end_y) >= MAX_ROW) ? 3'd7 : end_y[2:0];
                    walk_page_next   = PG_W'(y_first >> 3);
                    walk_column_next = COL_W'(x_first);
                end
            end
            ST_WALK:
            begin
                mem_re          = 1'b1;
                wr_pending_next = 1'b1;
                wr_addr_next    = walk_addr;
                wr_mask_next    = walk_mask;
                if (walk_column_reg == col_last_reg)
                begin
                    if (walk_page_reg == page_last_reg)
                    begin
                        walk_page_next   = '0;
                        walk_column_next = '0;
                    end
                    else
                    begin
                        walk_page_next   = walk_page_reg + 1'b1;
                        walk_column_next = col_first_reg;
                    end
                end
                else
                begin
                    walk_column_next = walk_column_reg + 1'b1;
                end
            end
            ST_READ:
            begin
                mem_re           = 1'b1;
                walk_page_next   = '0;
                walk_column_next = '0;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    pending_next   = 1'b0;
                    read_byte_next = read_ok_reg ? rd_data_reg : BYTE_EMPTY;
                end
            end
            default:
            begin
                pending_next = 1'b0;
            end
        endcase
    end

    assign mem_we    = (state_reg == ST_CLEAR) || wr_pending_reg;
    assign mem_waddr = (state_reg == ST_CLEAR) ? clear_addr_reg : wr_addr_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? BYTE_EMPTY
                     : (ink_reg == INK_WHITE) ? (rd_data_reg | wr_mask_reg)
                     : (rd_data_reg & ~wr_mask_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_store[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= frame_store[walk_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clear_addr_reg  <= '0;
            pending_reg     <= 1'b0;
            read_ok_reg     <= 1'b0;
            wr_pending_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            walk_page_reg   <= '0;
            walk_column_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            clear_addr_reg  <= clear_addr_next;
            pending_reg     <= pending_next;
            read_ok_reg     <= read_ok_next;
            wr_pending_reg  <= wr_pending_next;
            out_valid_reg   <= out_valid_next;
            walk_page_reg   <= walk_page_next;
            walk_column_reg <= walk_column_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_first_reg  <= col_first_next;
        col_last_reg   <= col_last_next;
        page_first_reg <= page_first_next;
        page_last_reg  <= page_last_next;
        seg_first_reg  <= seg_first_next;
        seg_last_reg   <= seg_last_next;
        ink_reg        <= ink_next;
        wr_addr_reg    <= wr_addr_next;
        wr_mask_reg    <= wr_mask_next;
        read_byte_reg  <= read_byte_next;
    end

    assign out_valid = out_valid_reg;
    assign read_byte = read_byte_reg;

    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !wr_pending_reg)
        else $error("pending write-back overlaps clearing sweep");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg != ST_IDLE))
        else $error("accepted beat did not start work");

    a_write_follows_walk: assert property (@(posedge clk) disable iff (!rst_n)
        wr_pending_reg |-> ($past(state_reg) == ST_WALK))
        else $error("write-back without a walk read");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> ($past(state_reg) == ST_FINISH))
        else $error("result beat raised outside finish");

    a_idle_flushed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!pending_reg && !wr_pending_reg))
        else $error("idle with command still in flight");

endmodule

`default_nettype wire
